[sv/bal_pkg.sv]
// Shared types and constants for the bounded array list.
package bal_pkg;

  localparam int DATA_W = 32;
  localparam int POS_W  = 5;
  localparam int CAP_W  = 5;
  localparam int CNT_W  = 5;
  localparam int OP_W   = 3;
  localparam int STAT_W = 2;

  localparam logic [CAP_W-1:0] CAPACITY_RST = 5'd16;

  typedef enum logic [OP_W-1:0] {
    OP_READ      = 3'd0,
    OP_INS_AT    = 3'd1,
    OP_DEL_AT    = 3'd2,
    OP_INS_FIRST = 3'd3,
    OP_INS_LAST  = 3'd4,
    OP_DEL_FIRST = 3'd5,
    OP_DEL_LAST  = 3'd6
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  // Control handed from the decoder to the cells and the count register.
  typedef struct packed {
    logic    ins;       // insert: cells at and above the slot move up
    logic    del;       // count goes down by one
    logic    shift_dn;  // cells at and above the slot move down
    logic    rd;        // successful read
    status_t status;
  } ctl_t;

endpackage

[sv/bounded_array_list.sv]
// Top level of the bounded array list: decoder, row of cells, result and config registers.
//
// The block keeps an ordered list of signed 32-bit words, held in a row of
// DEPTH identical cells. Cell k holds entry k; on an insert every cell above
// the slot takes the word of its lower neighbor, on a delete at a position or
// at the front every cell at or above the slot takes the word of its upper
// neighbor, all in the same cycle. An operation word is taken at a rising edge
// where start is high and busy is low. Busy is never raised: every operation
// finishes in the cycle that takes it, so a new word may follow in every cycle
// and the rate is one word per clock, set by the shift across the row of cells.
// The result word (status, read value, new count) appears on the out_ ports
// in the cycle after the operation was taken, marked by out_valid, which is
// high for a single cycle per result. The receiver cannot hold results off.
// The capacity register sits at byte address 0 of the APB-style port; the user
// must write it only while no operation is in flight, which the block itself does not enforce. It resets to 16.
// A synchronous reset empties the list and clears out_valid; the entry words
// themselves are not cleared, since no entry is read before it is written.
module bounded_array_list #(
  parameter int DEPTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [bal_pkg::OP_W-1:0]     in_op,
  input  logic [bal_pkg::POS_W-1:0]    in_position,
  input  logic signed [bal_pkg::DATA_W-1:0] in_value,
  output logic                         out_valid,
  output logic [bal_pkg::STAT_W-1:0]   out_status,
  output logic signed [bal_pkg::DATA_W-1:0] out_read_value,
  output logic [bal_pkg::CNT_W-1:0]    out_entry_count,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import bal_pkg::*;

  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);

  logic                  accept;
  ctl_t                  ctl;
  logic [IDX_W-1:0]      ins_idx;
  logic [IDX_W-1:0]      del_idx;
  logic [IDX_W-1:0]      rd_idx;
  logic [OCC_W-1:0]      occ_r;
  logic [OCC_W-1:0]      occ_nxt;
  logic [CAP_W-1:0]      cap_r;
  logic [DATA_W-1:0]     cell_data [DEPTH];

  logic                  valid_r;
  logic [STAT_W-1:0]     status_r;
  logic [DATA_W-1:0]     rdval_r;
  logic [DATA_W-1:0]     rdval_nxt;
  logic [CNT_W-1:0]      count_r;

  // Busy is tied low, so the block is always ready.
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  bal_ctrl #(
    .DEPTH (DEPTH),
    .OCC_W (OCC_W),
    .IDX_W (IDX_W)
  ) u_ctrl (
    .start   (accept),
    .op      (in_op),
    .pos     (in_position),
    .cap     (cap_r),
    .occ     (occ_r),
    .ctl     (ctl),
    .ins_idx (ins_idx),
    .del_idx (del_idx),
    .rd_idx  (rd_idx),
    .occ_nxt (occ_nxt)
  );

  // The row of cells. The ends have no neighbor; what they would take there
  // lands beyond the last valid entry and is never read.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] left_w;
    logic [DATA_W-1:0] right_w;

    if (i == 0) begin : g_lo
      assign left_w = '0;
    end else begin : g_lo
      assign left_w = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_hi
      assign right_w = '0;
    end else begin : g_hi
      assign right_w = cell_data[i+1];
    end

    bal_cell #(
      .IDX   (i),
      .IDX_W (IDX_W)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .ins_idx    (ins_idx),
      .del_idx    (del_idx),
      .value      (in_value),
      .left_data  (left_w),
      .right_data (right_w),
      .data       (cell_data[i])
    );
  end

  // A read picks the addressed cell; any other outcome reports zero.
  assign rdval_nxt = ctl.rd ? cell_data[rd_idx] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      occ_r   <= occ_nxt;
      valid_r <= accept;
    end
  end

  // Result payload needs no reset; out_valid qualifies it.
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= ctl.status;
      rdval_r  <= rdval_nxt;
      count_r  <= CNT_W'(occ_nxt);
    end
  end

  assign out_valid       = valid_r;
  assign out_status      = status_r;
  assign out_read_value  = rdval_r;
  assign out_entry_count = count_r;

  // Configuration port. Only the capacity register exists, at address 0.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAPACITY_RST;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      cap_r <= pwdata[CAP_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {{(32 - CAP_W){1'b0}}, cap_r} : 32'd0;

  // The count never runs past the number of cells.
  a_occ_bound : assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(DEPTH))
    else $error("occupancy above built depth");

  // Each taken operation gives exactly one result in the next cycle.
  a_one_result : assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("result strobe missing after an operation");

  // An insert grows the list by one, and the reported count follows.
  a_ins_count : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && ctl.ins) |=> (occ_r == $past(occ_r) + OCC_W'(1))
                            && (out_entry_count == CNT_W'(occ_r)))
    else $error("insert did not grow the list by one");

  // A successful read always reports ok.
  a_read_ok : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && ctl.rd) |=> (out_status == ST_OK))
    else $error("successful read reported a failure status");

endmodule

[sv/bal_cell.sv]
// One storage cell of the list: holds one word and trades it with its neighbors.
module bal_cell #(
  parameter int IDX   = 0,
  parameter int IDX_W = 4
) (
  input  logic                        clk,
  input  bal_pkg::ctl_t               ctl,
  input  logic [IDX_W-1:0]            ins_idx,
  input  logic [IDX_W-1:0]            del_idx,
  input  logic [bal_pkg::DATA_W-1:0]  value,
  input  logic [bal_pkg::DATA_W-1:0]  left_data,
  input  logic [bal_pkg::DATA_W-1:0]  right_data,
  output logic [bal_pkg::DATA_W-1:0]  data
);
  import bal_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctl.ins) begin
      if (MY_IDX == ins_idx) begin
        data_nxt = value;
      end else if (MY_IDX > ins_idx) begin
        data_nxt = left_data;
      end
    end else if (ctl.shift_dn) begin
      if (MY_IDX >= del_idx) begin
        data_nxt = right_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

[sv/bal_ctrl.sv]
// Operation decoder: checks the operation against the count, capacity and position.
module bal_ctrl #(
  parameter int DEPTH = 16,
  parameter int OCC_W = 5,
  parameter int IDX_W = 4
) (
  input  logic                       start,
  input  logic [bal_pkg::OP_W-1:0]   op,
  input  logic [bal_pkg::POS_W-1:0]  pos,
  input  logic [bal_pkg::CAP_W-1:0]  cap,
  input  logic [OCC_W-1:0]           occ,
  output bal_pkg::ctl_t              ctl,
  output logic [IDX_W-1:0]           ins_idx,
  output logic [IDX_W-1:0]           del_idx,
  output logic [IDX_W-1:0]           rd_idx,
  output logic [OCC_W-1:0]           occ_nxt
);
  import bal_pkg::*;

  localparam int CMP_W = (OCC_W > POS_W) ? OCC_W : POS_W;
  localparam int CW    = (CMP_W > CAP_W) ? CMP_W : CAP_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] occ_ext;
  logic [CW-1:0]    cap_ext;
  logic [CW-1:0]    eff_cap;
  logic             full;
  logic             empty;
  ctl_t             raw;

  assign pos_ext = CMP_W'(pos);
  assign occ_ext = CMP_W'(occ);
  assign cap_ext = CW'(cap);

  // A zero capacity acts as one, anything above the built depth as the depth.
  always_comb begin
    if (cap_ext == '0) begin
      eff_cap = CW'(1);
    end else if (cap_ext > DEPTH_C) begin
      eff_cap = DEPTH_C;
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign full  = CW'(occ) >= eff_cap;
  assign empty = (occ == '0);

  always_comb begin
    raw        = '0;
    raw.status = ST_OK;
    ins_idx    = '0;
    del_idx    = '0;
    rd_idx     = IDX_W'(pos_ext);
    unique case (op_t'(op))
      OP_READ: begin
        if (empty) begin
          raw.status = ST_EMPTY;
        end else if (pos_ext >= occ_ext) begin
          raw.status = ST_BADPOS;
        end else begin
          raw.rd = 1'b1;
        end
      end
      OP_INS_AT: begin
        if (full) begin
          raw.status = ST_FULL;
        end else if (pos_ext > occ_ext) begin
          raw.status = ST_BADPOS;
        end else begin
          raw.ins = 1'b1;
          ins_idx = IDX_W'(pos_ext);
        end
      end
      OP_DEL_AT: begin
        if (empty) begin
          raw.status = ST_EMPTY;
        end else if (pos_ext >= occ_ext) begin
          raw.status = ST_BADPOS;
        end else begin
          raw.del      = 1'b1;
          raw.shift_dn = 1'b1;
          del_idx      = IDX_W'(pos_ext);
        end
      end
      OP_INS_FIRST: begin
        if (full) begin
          raw.status = ST_FULL;
        end else begin
          raw.ins = 1'b1;
        end
      end
      OP_INS_LAST: begin
        if (full) begin
          raw.status = ST_FULL;
        end else begin
          raw.ins = 1'b1;
          ins_idx = IDX_W'(occ_ext);
        end
      end
      OP_DEL_FIRST: begin
        if (empty) begin
          raw.status = ST_EMPTY;
        end else begin
          raw.del      = 1'b1;
          raw.shift_dn = 1'b1;
        end
      end
      OP_DEL_LAST: begin
        if (empty) begin
          raw.status = ST_EMPTY;
        end else begin
          raw.del = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Nothing moves unless a word is taken in this cycle.
  always_comb begin
    ctl          = raw;
    ctl.ins      = raw.ins & start;
    ctl.del      = raw.del & start;
    ctl.shift_dn = raw.shift_dn & start;
    ctl.rd       = raw.rd & start;
  end

  always_comb begin
    if (ctl.ins) begin
      occ_nxt = occ + OCC_W'(1);
    end else if (ctl.del) begin
      occ_nxt = occ - OCC_W'(1);
    end else begin
      occ_nxt = occ;
    end
  end

endmodule
